// File: sv/pisf_pkg.sv
// Shared types and constants of the pairwise inverse-square force block.
package pisf_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int COEF_W   = 32;
    localparam int PAIR_W   = 2 * COEF_W;
    localparam int PROD_W   = 3 * COEF_W;
    localparam int AMAG_W   = PROD_W + 1;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = 2 * COORD_W + 2;
    localparam int ROOT_W   = COORD_W + FRAC_W + 1;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int DIG_W    = 8;
    localparam int MUL_N    = (ROOT_W + DIG_W - 1) / DIG_W;
    localparam int YM_W     = MUL_N * DIG_W;
    localparam int NUM_W    = AMAG_W + YM_W;
    localparam int DEN_W    = SUM_W + YM_W;
    localparam int DIVN_W   = NUM_W + FRAC_W;
    localparam int FORCE_W  = 48;
    localparam int QUO_W    = FORCE_W + 1;
    localparam int FRONT_N  = 5;
    localparam int LATENCY  = FRONT_N + ROOT_W + MUL_N + QUO_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEC_COEF = 2'd1;

    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] self_pos_x;
        logic signed [COORD_W-1:0] self_pos_y;
        logic signed [COORD_W-1:0] self_pos_z;
        logic signed [COORD_W-1:0] other_pos_x;
        logic signed [COORD_W-1:0] other_pos_y;
        logic signed [COORD_W-1:0] other_pos_z;
        logic [COEF_W-1:0]         self_mass;
        logic [COEF_W-1:0]         other_mass;
        logic signed [COEF_W-1:0]  self_charge;
        logic signed [COEF_W-1:0]  other_charge;
        logic                      self_gravity;
        logic                      other_gravity;
    } t_in;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      coincident;
        logic                      saturated;
    } t_out;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_sgn;

endpackage

// File: sv/pisf_sqrt_cell.sv
// One digit step of the integer square root chain.
module pisf_sqrt_cell #(
    parameter int ROOT_W = 49
) (
    input  logic                i_clk,
    input  logic [2*ROOT_W-1:0] i_rad,
    input  logic [ROOT_W:0]     i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    output logic [2*ROOT_W-1:0] o_rad,
    output logic [ROOT_W:0]     o_rem,
    output logic [ROOT_W-1:0]   o_root
);

    logic [ROOT_W+2:0] pull;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              take;

    always_comb begin
        pull  = {i_rem, i_rad[2*ROOT_W-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        diff  = pull - trial;
        take  = (pull >= trial);
    end

    always_ff @(posedge i_clk) begin
        o_rad  <= {i_rad[2*ROOT_W-3:0], 2'b00};
        o_rem  <= take ? diff[ROOT_W:0] : pull[ROOT_W:0];
        o_root <= {i_root[ROOT_W-2:0], take};
    end

endmodule

// File: sv/pisf_mac_cell.sv
// One digit step of a multiply: add operand times one digit of the multiplier.
module pisf_mac_cell #(
    parameter int XW  = 66,
    parameter int YW  = 56,
    parameter int PW  = 122,
    parameter int DW  = 8,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    input  logic [PW-1:0] i_acc,
    output logic [XW-1:0] o_x,
    output logic [YW-1:0] o_y,
    output logic [PW-1:0] o_acc
);

    logic [XW+DW-1:0] pp;
    logic [PW-1:0]    n_acc;

    always_comb begin
        pp    = (XW+DW)'(i_x) * (XW+DW)'(i_y[IDX*DW +: DW]);
        n_acc = i_acc + (PW'(pp) << (IDX * DW));
    end

    always_ff @(posedge i_clk) begin
        o_x   <= i_x;
        o_y   <= i_y;
        o_acc <= n_acc;
    end

endmodule

// File: sv/pisf_div_cell.sv
// One quotient bit of the restoring division chain.
module pisf_div_cell
    import pisf_pkg::*;
#(
    parameter int NW = 162,
    parameter int DW = 122,
    parameter int K  = 0
) (
    input  logic             i_clk,
    input  logic [NW-1:0]    i_rem,
    input  logic [DW-1:0]    i_den,
    input  logic [QUO_W-1:0] i_q,
    output logic [NW-1:0]    o_rem,
    output logic [DW-1:0]    o_den,
    output logic [QUO_W-1:0] o_q
);

    localparam int CW = (NW > DW + K) ? NW : DW + K;

    logic [CW-1:0]    rem_ext;
    logic [CW-1:0]    den_sh;
    logic [CW-1:0]    diff;
    logic             take;
    logic [QUO_W-1:0] n_q;

    always_comb begin
        rem_ext = CW'(i_rem);
        den_sh  = CW'(i_den) << K;
        diff    = rem_ext - den_sh;
        take    = (rem_ext >= den_sh);
        n_q     = i_q;
        n_q[K]  = take;
    end

    always_ff @(posedge i_clk) begin
        o_rem <= take ? diff[NW-1:0] : i_rem;
        o_den <= i_den;
        o_q   <= n_q;
    end

endmodule

// File: sv/pairwise_inverse_square_force.sv
// The strobe is high in the cycle just before the edge that takes the result.
// Throughput: one transaction per cycle when not busy; every stage is a register,
// nothing stalls.
// The pipeline is mostly chains of cells: square root (one root bit per cell), multiply
// (one 8-bit digit per cell) and division (one quotient bit per cell).
// Reset: synchronous, active low; clears the in-flight valid bits and the coefficients
// and sets busy, which clears at an edge with reset released. The receiver cannot stall.
module pairwise_inverse_square_force
    import pisf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in                  i_in,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output logic                 o_strobe,
    output t_out                 o_res
);

    typedef struct packed {
        logic [AMAG_W-1:0]         amag;
        logic [2:0]                neg;
        logic [2:0][DIFF_W-1:0]    dabs;
        logic [SUM_W-1:0]          sum;
        logic                      zero;
    } t_sq_sb;

    // Control and coefficient registers
    logic               r_busy;
    logic [LATENCY-1:0] r_vld;
    logic [COEF_W-1:0]  r_grav_coef;
    logic [COEF_W-1:0]  r_elec_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_vld       <= '0;
            r_grav_coef <= '0;
            r_elec_coef <= '0;
        end else begin
            r_busy <= 1'b0;
            // advance the valid bit of every transaction one stage per cycle
            r_vld  <= {r_vld[LATENCY-2:0], i_start & ~r_busy};
            if (i_cfg_valid && !r_busy) begin
                unique case (i_cfg_index)
                    CFG_GRAV_COEF: r_grav_coef <= i_cfg_data;
                    CFG_ELEC_COEF: r_elec_coef <= i_cfg_data;
                    default: ; // drop writes to unknown registers
                endcase
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign o_strobe    = r_vld[LATENCY-1];

    // Stage 1: position differences, magnitudes and signs
    logic signed [COORD_W-1:0] self_pos  [3];
    logic signed [COORD_W-1:0] other_pos [3];
    logic signed [DIFF_W-1:0]  n_diff    [3];
    logic [DIFF_W-1:0]         n1_dabs   [3];
    logic [2:0]                n1_dneg;

    assign self_pos[0]  = i_in.self_pos_x;
    assign self_pos[1]  = i_in.self_pos_y;
    assign self_pos[2]  = i_in.self_pos_z;
    assign other_pos[0] = i_in.other_pos_x;
    assign other_pos[1] = i_in.other_pos_y;
    assign other_pos[2] = i_in.other_pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_diff[a]  = DIFF_W'(other_pos[a]) - DIFF_W'(self_pos[a]);
            n1_dneg[a] = n_diff[a][DIFF_W-1];
            n1_dabs[a] = n1_dneg[a] ? DIFF_W'(-n_diff[a]) : DIFF_W'(n_diff[a]);
        end
    end

    logic [DIFF_W-1:0] r1_dabs [3];
    logic [2:0]        r1_dneg;
    logic              r1_grav;
    logic [COEF_W-1:0] r1_m1;
    logic [COEF_W-1:0] r1_m2;
    logic [COEF_W-1:0] r1_c1abs;
    logic [COEF_W-1:0] r1_c2abs;
    logic              r1_cdiff;

    always_ff @(posedge i_clk) begin
        r1_dabs  <= n1_dabs;
        r1_dneg  <= n1_dneg;
        r1_grav  <= i_in.self_gravity & i_in.other_gravity;
        r1_m1    <= i_in.self_mass;
        r1_m2    <= i_in.other_mass;
        r1_c1abs <= i_in.self_charge[COEF_W-1]
                  ? COEF_W'(-i_in.self_charge) : COEF_W'(i_in.self_charge);
        r1_c2abs <= i_in.other_charge[COEF_W-1]
                  ? COEF_W'(-i_in.other_charge) : COEF_W'(i_in.other_charge);
        r1_cdiff <= i_in.self_charge[COEF_W-1] ^ i_in.other_charge[COEF_W-1];
    end

    // Stage 2: squares, coefficient times first factor
    logic [SQ_W-1:0]   r2_sq [3];
    logic [PAIR_W-1:0] r2_gm;
    logic [PAIR_W-1:0] r2_em;
    logic [DIFF_W-1:0] r2_dabs [3];
    logic [2:0]        r2_dneg;
    logic [COEF_W-1:0] r2_m2;
    logic [COEF_W-1:0] r2_c2abs;
    logic              r2_cdiff;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r2_sq[a] <= SQ_W'(r1_dabs[a]) * SQ_W'(r1_dabs[a]);
        end
        r2_gm    <= r1_grav ? PAIR_W'(r_grav_coef) * PAIR_W'(r1_m1) : '0;
        r2_em    <= PAIR_W'(r_elec_coef) * PAIR_W'(r1_c1abs);
        r2_dabs  <= r1_dabs;
        r2_dneg  <= r1_dneg;
        r2_m2    <= r1_m2;
        r2_c2abs <= r1_c2abs;
        r2_cdiff <= r1_cdiff;
    end

    // Stage 3: squared distance, partial products of the second factor
    logic [SUM_W-1:0]  r3_sum;
    logic [PAIR_W-1:0] r3_gp_lo;
    logic [PAIR_W-1:0] r3_gp_hi;
    logic [PAIR_W-1:0] r3_ep_lo;
    logic [PAIR_W-1:0] r3_ep_hi;
    logic [DIFF_W-1:0] r3_dabs [3];
    logic [2:0]        r3_dneg;
    logic              r3_cdiff;

    always_ff @(posedge i_clk) begin
        r3_sum   <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
        r3_gp_lo <= PAIR_W'(r2_gm[COEF_W-1:0]) * PAIR_W'(r2_m2);
        r3_gp_hi <= PAIR_W'(r2_gm[PAIR_W-1:COEF_W]) * PAIR_W'(r2_m2);
        r3_ep_lo <= PAIR_W'(r2_em[COEF_W-1:0]) * PAIR_W'(r2_c2abs);
        r3_ep_hi <= PAIR_W'(r2_em[PAIR_W-1:COEF_W]) * PAIR_W'(r2_c2abs);
        r3_dabs  <= r2_dabs;
        r3_dneg  <= r2_dneg;
        r3_cdiff <= r2_cdiff;
    end

    // Stage 4: assemble the gravity and Coulomb magnitudes
    logic [PROD_W-1:0] r4_gp;
    logic [PROD_W-1:0] r4_ep;
    logic [SUM_W-1:0]  r4_sum;
    logic              r4_zero;
    logic [DIFF_W-1:0] r4_dabs [3];
    logic [2:0]        r4_dneg;
    logic              r4_cdiff;

    always_ff @(posedge i_clk) begin
        r4_gp    <= PROD_W'(r3_gp_lo) + {r3_gp_hi, COEF_W'(0)};
        r4_ep    <= PROD_W'(r3_ep_lo) + {r3_ep_hi, COEF_W'(0)};
        r4_sum   <= r3_sum;
        r4_zero  <= (r3_sum == '0);
        r4_dabs  <= r3_dabs;
        r4_dneg  <= r3_dneg;
        r4_cdiff <= r3_cdiff;
    end

    // Stage 5: net coefficient; positive attracts, negative repels
    logic [AMAG_W-1:0] n5_amag;
    logic              n5_aneg;
    t_sq_sb            r5_sb;

    always_comb begin
        if (r4_cdiff) begin
            n5_amag = AMAG_W'(r4_gp) + AMAG_W'(r4_ep);
            n5_aneg = 1'b0;
        end else if (r4_gp >= r4_ep) begin
            n5_amag = AMAG_W'(r4_gp - r4_ep);
            n5_aneg = 1'b0;
        end else begin
            n5_amag = AMAG_W'(r4_ep - r4_gp);
            n5_aneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_sb.amag <= n5_amag;
        r5_sb.neg  <= r4_dneg ^ {3{n5_aneg}};
        for (int a = 0; a < 3; a++) begin
            r5_sb.dabs[a] <= r4_dabs[a];
        end
        r5_sb.sum  <= r4_sum;
        r5_sb.zero <= r4_zero;
    end

    // Square root chain: distance scaled by 2^16
    logic [RAD_W-1:0]    sq_rad  [ROOT_W+1];
    logic [ROOT_W:0]     sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]   sq_root [ROOT_W+1];
    t_sq_sb              r_sq_sb [ROOT_W];

    assign sq_rad[0]  = RAD_W'({r5_sb.sum, (2*FRAC_W)'(0)});
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        pisf_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
            .i_clk  (i_clk),
            .i_rad  (sq_rad[k]),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .o_rad  (sq_rad[k+1]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1])
        );
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                r_sq_sb[k] <= r5_sb;
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                r_sq_sb[k] <= r_sq_sb[k-1];
            end
        end
    end

    // Multiply chain: denominator S*Q and the three numerators |A|*|D|
    logic [SUM_W-1:0]  mu_den_x   [MUL_N+1];
    logic [YM_W-1:0]   mu_den_y   [MUL_N+1];
    logic [DEN_W-1:0]  mu_den_acc [MUL_N+1];
    logic [AMAG_W-1:0] mu_num_x   [3][MUL_N+1];
    logic [YM_W-1:0]   mu_num_y   [3][MUL_N+1];
    logic [NUM_W-1:0]  mu_num_acc [3][MUL_N+1];
    t_sgn              r_mu_sb    [MUL_N];

    assign mu_den_x[0]   = r_sq_sb[ROOT_W-1].sum;
    assign mu_den_y[0]   = YM_W'(sq_root[ROOT_W]);
    assign mu_den_acc[0] = '0;

    for (genvar a = 0; a < 3; a++) begin : g_num_in
        assign mu_num_x[a][0]   = r_sq_sb[ROOT_W-1].amag;
        assign mu_num_y[a][0]   = YM_W'(r_sq_sb[ROOT_W-1].dabs[a]);
        assign mu_num_acc[a][0] = '0;
    end

    for (genvar k = 0; k < MUL_N; k++) begin : g_mul
        pisf_mac_cell #(
            .XW(SUM_W), .YW(YM_W), .PW(DEN_W), .DW(DIG_W), .IDX(k)
        ) u_den (
            .i_clk (i_clk),
            .i_x   (mu_den_x[k]),
            .i_y   (mu_den_y[k]),
            .i_acc (mu_den_acc[k]),
            .o_x   (mu_den_x[k+1]),
            .o_y   (mu_den_y[k+1]),
            .o_acc (mu_den_acc[k+1])
        );
        for (genvar a = 0; a < 3; a++) begin : g_axis
            pisf_mac_cell #(
                .XW(AMAG_W), .YW(YM_W), .PW(NUM_W), .DW(DIG_W), .IDX(k)
            ) u_num (
                .i_clk (i_clk),
                .i_x   (mu_num_x[a][k]),
                .i_y   (mu_num_y[a][k]),
                .i_acc (mu_num_acc[a][k]),
                .o_x   (mu_num_x[a][k+1]),
                .o_y   (mu_num_y[a][k+1]),
                .o_acc (mu_num_acc[a][k+1])
            );
        end
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                r_mu_sb[k].neg  <= r_sq_sb[ROOT_W-1].neg;
                r_mu_sb[k].zero <= r_sq_sb[ROOT_W-1].zero;
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                r_mu_sb[k] <= r_mu_sb[k-1];
            end
        end
    end

    // Division chain: one quotient bit per cell, overflow bit first
    logic [DIVN_W-1:0] dv_rem [3][QUO_W+1];
    logic [DEN_W-1:0]  dv_den [3][QUO_W+1];
    logic [QUO_W-1:0]  dv_q   [3][QUO_W+1];
    t_sgn              r_dv_sb [QUO_W];

    for (genvar a = 0; a < 3; a++) begin : g_div_in
        assign dv_rem[a][0] = {mu_num_acc[a][MUL_N], FRAC_W'(0)};
        assign dv_den[a][0] = mu_den_acc[MUL_N];
        assign dv_q[a][0]   = '0;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        for (genvar a = 0; a < 3; a++) begin : g_axis
            pisf_div_cell #(
                .NW(DIVN_W), .DW(DEN_W), .K(QUO_W - 1 - k)
            ) u_cell (
                .i_clk (i_clk),
                .i_rem (dv_rem[a][k]),
                .i_den (dv_den[a][k]),
                .i_q   (dv_q[a][k]),
                .o_rem (dv_rem[a][k+1]),
                .o_den (dv_den[a][k+1]),
                .o_q   (dv_q[a][k+1])
            );
        end
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                r_dv_sb[k] <= r_mu_sb[MUL_N-1];
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                r_dv_sb[k] <= r_dv_sb[k-1];
            end
        end
    end

    // Output stage: clip to the force range, apply sign, zero when coincident
    logic [FORCE_W-1:0] lim    [3];
    logic [FORCE_W-1:0] mag    [3];
    logic [FORCE_W-1:0] n_force[3];
    logic [2:0]         over;
    t_sgn               fin;
    t_out               r_res;

    always_comb begin
        fin = r_dv_sb[QUO_W-1];
        for (int a = 0; a < 3; a++) begin
            lim[a]     = fin.neg[a] ? FORCE_NEG_MAX : FORCE_POS_MAX;
            over[a]    = dv_q[a][QUO_W][FORCE_W] | (dv_q[a][QUO_W][FORCE_W-1:0] > lim[a]);
            mag[a]     = over[a] ? lim[a] : dv_q[a][QUO_W][FORCE_W-1:0];
            n_force[a] = fin.zero ? '0 : (fin.neg[a] ? FORCE_W'(-mag[a]) : mag[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.force_x    <= n_force[0];
        r_res.force_y    <= n_force[1];
        r_res.force_z    <= n_force[2];
        r_res.coincident <= fin.zero;
        r_res.saturated  <= ~fin.zero & (|over);
    end

    assign o_res = r_res;

endmodule

// File: sv/pisf_checker.sv
// Port-level checks of the pairwise inverse-square force block, with its bind.
module pisf_checker
    import pisf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_strobe,
    input t_out                 o_res
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_strobe)
        else $error("accepted transaction produced no result");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without an accepted transaction");

    a_coincident_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.coincident) |->
            (o_res.force_x == '0 && o_res.force_y == '0 && o_res.force_z == '0
             && !o_res.saturated))
        else $error("coincident result not zero");

    a_saturated_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.saturated) |->
            (o_res.force_x == FORCE_POS_MAX || o_res.force_x == FORCE_NEG_MAX
             || o_res.force_y == FORCE_POS_MAX || o_res.force_y == FORCE_NEG_MAX
             || o_res.force_z == FORCE_POS_MAX || o_res.force_z == FORCE_NEG_MAX))
        else $error("saturated flag without a clipped component");

endmodule

bind pairwise_inverse_square_force pisf_checker u_pisf_checker (.*);

// File: dv/pairwise_inverse_square_force_tb.sv
// Self-checking testbench for the pairwise inverse-square force block.
module pairwise_inverse_square_force_tb;
    import pisf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that no register answers to; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [COEF_W-1:0]    COEF_ONE    = 32'h0001_0000;
    localparam logic [COEF_W-1:0]    COEF_MAX    = 32'hFFFF_FFFF;
    localparam int                   IDLE_LIMIT  = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    t_in                  i_in;
    logic                 o_busy;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;
    logic                 o_strobe;
    t_out                 o_res;

    // Coefficients as the block should hold them.
    logic [COEF_W-1:0] grav_coef_q;
    logic [COEF_W-1:0] elec_coef_q;

    t_out pending_forces[$];
    int   error_count;
    int   idle_cycles;

    pairwise_inverse_square_force DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_in        (i_in),
        .o_busy      (o_busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Integer square root, floor, one root bit at a time.
    function automatic logic [255:0] floor_sqrt(logic [255:0] x);
        logic [255:0] root;
        logic [255:0] trial;
        root = '0;
        for (int b = 70; b >= 0; b--) begin
            trial = root | (256'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Exact force on self from the partner, truncated toward zero and clipped.
    function automatic t_out pair_force(t_in p);
        t_out                  r;
        logic signed [33:0]    delta[3];
        logic [33:0]           dabs[3];
        logic [255:0]          sumsq;
        logic [255:0]          grav_term;
        logic [255:0]          elec_term;
        logic [255:0]          net_mag;
        logic [255:0]          den;
        logic [255:0]          quo;
        logic [255:0]          lim;
        logic [32:0]           q1_mag;
        logic [32:0]           q2_mag;
        logic                  q1_neg;
        logic                  q2_neg;
        logic                  repel;
        logic                  neg;
        logic [FORCE_W-1:0]    comp[3];

        r = '0;
        delta[0] = 34'(p.other_pos_x) - 34'(p.self_pos_x);
        delta[1] = 34'(p.other_pos_y) - 34'(p.self_pos_y);
        delta[2] = 34'(p.other_pos_z) - 34'(p.self_pos_z);
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            dabs[i] = delta[i] < 0 ? -delta[i] : delta[i];
            sumsq   = sumsq + 256'(dabs[i]) * 256'(dabs[i]);
        end
        if (sumsq == 0) begin
            r.coincident = 1'b1;
            return r;
        end

        grav_term = '0;
        if (p.self_gravity && p.other_gravity)
            grav_term = 256'(grav_coef_q) * 256'(p.self_mass) * 256'(p.other_mass);
        q1_neg = p.self_charge[COEF_W-1];
        q2_neg = p.other_charge[COEF_W-1];
        q1_mag = q1_neg ? 33'h1_0000_0000 - {1'b0, p.self_charge} : {1'b0, p.self_charge};
        q2_mag = q2_neg ? 33'h1_0000_0000 - {1'b0, p.other_charge} : {1'b0, p.other_charge};
        elec_term = 256'(elec_coef_q) * 256'(q1_mag) * 256'(q2_mag);

        // Net coefficient: positive pulls self toward the partner.
        repel = 1'b0;
        if (q1_neg != q2_neg)
            net_mag = grav_term + elec_term;
        else if (grav_term >= elec_term)
            net_mag = grav_term - elec_term;
        else begin
            net_mag = elec_term - grav_term;
            repel   = 1'b1;
        end

        den = sumsq * floor_sqrt(sumsq << 32);
        for (int i = 0; i < 3; i++) begin
            neg = repel != (delta[i] < 0);
            lim = neg ? 256'(FORCE_NEG_MAX) : 256'(FORCE_POS_MAX);
            quo = ((net_mag * 256'(dabs[i])) << 16) / den;
            if (quo > lim) begin
                quo         = lim;
                r.saturated = 1'b1;
            end
            comp[i] = neg ? -quo[FORCE_W-1:0] : quo[FORCE_W-1:0];
        end
        r.force_x = comp[0];
        r.force_y = comp[1];
        r.force_z = comp[2];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, many back-to-back.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            8:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            9:       return '0;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_scalar();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return '0;
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    // Partner close to self most of the time so the force stays in range.
    function automatic logic [31:0] near_coord(logic [31:0] base);
        case ($urandom_range(0, 9))
            0:       return base;
            1, 2:    return $urandom;
            default: return base + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic t_in rand_pair();
        t_in p;
        p.self_pos_x    = rand_coord();
        p.self_pos_y    = rand_coord();
        p.self_pos_z    = rand_coord();
        if ($urandom_range(0, 19) == 0) begin
            p.other_pos_x = p.self_pos_x;
            p.other_pos_y = p.self_pos_y;
            p.other_pos_z = p.self_pos_z;
        end else begin
            p.other_pos_x = near_coord(p.self_pos_x);
            p.other_pos_y = near_coord(p.self_pos_y);
            p.other_pos_z = near_coord(p.self_pos_z);
        end
        p.self_mass     = rand_scalar();
        p.other_mass    = rand_scalar();
        p.self_charge   = rand_scalar();
        p.other_charge  = rand_scalar();
        p.self_gravity  = 1'($urandom_range(0, 1));
        p.other_gravity = 1'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic t_in make_pair(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                      logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [31:0] m1, logic [31:0] m2,
                                      logic [31:0] q1, logic [31:0] q2,
                                      logic g1, logic g2);
        t_in p;
        p.self_pos_x    = sx;
        p.self_pos_y    = sy;
        p.self_pos_z    = sz;
        p.other_pos_x   = ox;
        p.other_pos_y   = oy;
        p.other_pos_z   = oz;
        p.self_mass     = m1;
        p.other_mass    = m2;
        p.self_charge   = q1;
        p.other_charge  = q2;
        p.self_gravity  = g1;
        p.other_gravity = g2;
        return p;
    endfunction

    // Called at a falling edge. With gap 0 it returns at the falling edge after the
    // transaction with start held high, so a following item goes out back-to-back.
    task automatic send_pair(t_in p, int gap);
        i_in    = p;
        i_start = 1'b1;
        #1;
        while (o_busy) begin
            @(negedge i_clk);
            #1;
        end
        pending_forces.push_back(pair_force(p));
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Wait until every result is back, then let the pipeline empty out.
    task automatic drain_pipeline();
        i_start = 1'b0;
        while (pending_forces.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        i_start     = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        #1;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
            #1;
        end
        if (idx == CFG_GRAV_COEF)
            grav_coef_q = value;
        else if (idx == CFG_ELEC_COEF)
            elec_coef_q = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_coefs(logic [COEF_W-1:0] g, logic [COEF_W-1:0] e);
        drain_pipeline();
        write_coef(CFG_GRAV_COEF, g);
        write_coef(CFG_ELEC_COEF, e);
    endtask

    // Coefficients are zero out of reset: every non-coincident pair gives no force.
    task automatic test_reset_coefs();
        for (int n = 0; n < 6; n++) send_pair(rand_pair(), pick_gap());
    endtask

    task automatic test_directed();
        set_coefs(COEF_ONE, COEF_ONE);
        // Like charges repel, unlike attract, gravity with every flag pairing.
        send_pair(make_pair(0, 0, 0, COEF_ONE, 0, 0, COEF_ONE, COEF_ONE,
                            COEF_ONE, COEF_ONE, 1, 1), 0);
        send_pair(make_pair(0, 0, 0, 0, COEF_ONE, 0, 0, 0,
                            COEF_ONE, -COEF_ONE, 0, 0), 0);
        send_pair(make_pair(0, 0, 0, 0, 0, -COEF_ONE, 32'h0003_0000, COEF_ONE,
                            0, 0, 1, 0), 0);
        send_pair(make_pair(0, 0, 0, 0, 0, -COEF_ONE, 32'h0003_0000, COEF_ONE,
                            0, 0, 0, 1), 1);
        send_pair(make_pair(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000,
                            32'h0005_0000, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000,
                            1, 1), 0);
        // Coincident positions, at zero and at the extremes.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, COEF_MAX, COEF_MAX,
                            COEF_ONE, COEF_ONE, 1, 1), 0);
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, 1, 1), 2);
        // Widest separation: every axis from one extreme to the other, then two axes.
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            COEF_MAX, COEF_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1), 0);
        send_pair(make_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                            COEF_MAX, 0, 32'h8000_0000, 32'h8000_0000, 1, 1), 0);
        // Gravity exactly cancels the Coulomb push.
        send_pair(make_pair(0, 0, 0, 32'h0000_0001, 0, 0, COEF_ONE, COEF_ONE,
                            COEF_ONE, COEF_ONE, 1, 1), 0);

        set_coefs(COEF_MAX, COEF_MAX);
        // Unit and diagonal-unit distances with the largest products: clip both ways.
        send_pair(make_pair(0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0, COEF_MAX, COEF_MAX,
                            0, 0, 1, 1), 0);
        send_pair(make_pair(5, 5, 5, 5, 5, 6, 0, 0,
                            32'h8000_0000, 32'h8000_0000, 0, 0), 0);
        send_pair(make_pair(5, 5, 5, 5, 4, 5, 0, 0,
                            32'h7FFF_FFFF, 32'h8000_0000, 1, 0), 0);
        send_pair(make_pair(0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 1, 1), 3);

        // Writes to unused indexes must leave both coefficients alone.
        drain_pipeline();
        write_coef(CFG_SPARE_A, 32'h1234_5678);
        write_coef(CFG_SPARE_B, 32'hDEAD_BEEF);
        send_pair(make_pair(0, 0, 0, 32'h0010_0000, 32'h0003_0000, 0, COEF_ONE, COEF_ONE,
                            COEF_ONE, COEF_ONE, 1, 1), 0);
        send_pair(rand_pair(), 0);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_pair(rand_pair(), pick_gap());
    endtask

    // Result checker: compare each strobe with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_forces.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                error_count++;
            end else begin
                want = pending_forces.pop_front();
                if (o_res.force_x !== want.force_x) begin
                    $display("%0t: force_x exp %h got %h", $time, want.force_x, o_res.force_x);
                    error_count++;
                end
                if (o_res.force_y !== want.force_y) begin
                    $display("%0t: force_y exp %h got %h", $time, want.force_y, o_res.force_y);
                    error_count++;
                end
                if (o_res.force_z !== want.force_z) begin
                    $display("%0t: force_z exp %h got %h", $time, want.force_z, o_res.force_z);
                    error_count++;
                end
                if (o_res.coincident !== want.coincident) begin
                    $display("%0t: coincident exp %b got %b", $time, want.coincident,
                             o_res.coincident);
                    error_count++;
                end
                if (o_res.saturated !== want.saturated) begin
                    $display("%0t: saturated exp %b got %b", $time, want.saturated,
                             o_res.saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: abort when no transaction of any kind moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL pairwise_inverse_square_force");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        grav_coef_q = '0;
        elec_coef_q = '0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GRAV_COEF;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_coefs();
        test_directed();
        set_coefs(COEF_ONE, COEF_ONE);
        test_random(160);
        set_coefs(0, COEF_MAX);
        test_random(140);
        set_coefs(COEF_MAX, 0);
        test_random(140);
        set_coefs($urandom, $urandom_range(0, 32'h0010_0000));
        test_random(160);
        drain_pipeline();

        if (error_count == 0) begin
            $display("PASS pairwise_inverse_square_force");
        end else begin
            $display("FAIL pairwise_inverse_square_force");
        end
        $finish;
    end

endmodule

// File: pairwise_inverse_square_force.f
sv/pisf_pkg.sv
sv/pisf_sqrt_cell.sv
sv/pisf_mac_cell.sv
sv/pisf_div_cell.sv
sv/pairwise_inverse_square_force.sv
sv/pisf_checker.sv
dv/pairwise_inverse_square_force_tb.sv
